### hdl/hrg_pkg.sv
// Shared types and constants for the hard rod gas event step block.
`timescale 1ns / 1ps
package hrg_pkg;

   localparam int NUM_P     = 32;
   localparam int IDX_W     = 5;
   localparam int VAL_W     = 32;
   localparam int CNT_W     = 6;
   localparam int CSR_IDX_W = 2;
   localparam int DIVN_W    = 51;
   localparam int DIVD_W    = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_WALL  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_WALL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT      = 2'd2;

   localparam logic [1:0] MODE_LOAD = 2'd0;
   localparam logic [1:0] MODE_STEP = 2'd1;
   localparam logic [1:0] MODE_READ = 2'd2;

   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_LEFT  = 2'd1;
   localparam logic [1:0] KIND_PAIR  = 2'd2;
   localparam logic [1:0] KIND_RIGHT = 2'd3;

   typedef enum logic [1:0] {
      RSP_ZERO,
      RSP_READ,
      RSP_STEP
   } hrg_rsp_sel_type;

   typedef struct packed {
      logic [1:0]        mode;
      logic [4:0]        slot;
      logic signed [31:0] position_in;
      logic signed [31:0] velocity_in;
      logic [15:0]       mass_in;
      logic [30:0]       radius_in;
   } hrg_req_type;

   typedef struct packed {
      logic [1:0]        event_kind;
      logic [4:0]        event_index;
      logic [31:0]       event_time;
      logic signed [31:0] position_out;
      logic signed [31:0] velocity_out;
   } hrg_rsp_type;

   typedef struct packed {
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             cap;
      logic             clr_best;
      logic [1:0]       cand;
      logic [IDX_W-1:0] cand_idx;
      logic             mul_adv;
      logic             wr_pos;
      logic             wr_neg;
      logic             mul_mom;
      logic             sum_mom;
      logic             div_mom;
      logic             wr_pair0;
      logic             wr_pair1;
      logic [IDX_W-1:0] wr_addr;
      logic             wr_load;
      logic             rsp_load;
      hrg_rsp_sel_type  rsp_sel;
   } hrg_cmd_type;

   typedef struct packed {
      logic             n_zero;
      logic [IDX_W-1:0] last;
      logic             busy;
      logic [1:0]       kind;
      logic [IDX_W-1:0] idx;
   } hrg_status_type;

endpackage

### hdl/hrg_div.sv
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
module hrg_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [hrg_pkg::DIVN_W-1:0] dividend,
   input  logic [hrg_pkg::DIVD_W-1:0] divisor,
   output logic                       busy,
   output logic                       done,
   output logic [hrg_pkg::DIVN_W-1:0] quotient,
   output logic [hrg_pkg::DIVD_W-1:0] remainder
);
   import hrg_pkg::*;

   localparam logic [5:0] STEPS = 6'(DIVN_W);

   logic [5:0]        cnt_ff;
   logic              done_ff;
   logic [DIVN_W-1:0] q_ff;
   logic [DIVD_W-1:0] r_ff;
   logic [DIVD_W-1:0] d_ff;
   logic [DIVD_W:0]   trial;
   logic [DIVD_W:0]   diff;
   logic              ge;

   assign trial = {r_ff, q_ff[DIVN_W-1]};
   assign diff  = trial - {1'b0, d_ff};
   assign ge    = trial >= {1'b0, d_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= (cnt_ff == 6'd1);
         if (start) begin
            cnt_ff <= STEPS;
         end else if (cnt_ff != 6'd0) begin
            cnt_ff <= cnt_ff - 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff <= dividend;
         r_ff <= '0;
         d_ff <= divisor;
      end else if (cnt_ff != 6'd0) begin
         q_ff <= {q_ff[DIVN_W-2:0], ge};
         r_ff <= ge ? diff[DIVD_W-1:0] : trial[DIVD_W-1:0];
      end
   end

   assign busy      = (cnt_ff != 6'd0) || done_ff;
   assign done      = done_ff;
   assign quotient  = q_ff;
   assign remainder = r_ff;

endmodule

### hdl/hrg_dp.sv
// Datapath: particle stores, configuration, candidate times, advance and exchange.
`timescale 1ns / 1ps
module hrg_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  hrg_pkg::hrg_cmd_type          cmd,
   output hrg_pkg::hrg_status_type       status,
   input  hrg_pkg::hrg_req_type          req_beat,
   input  logic                          csr_we,
   input  logic [hrg_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [hrg_pkg::VAL_W-1:0]     csr_wdata,
   output hrg_pkg::hrg_rsp_type          rsp_beat
);
   import hrg_pkg::*;

   function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
      logic signed [31:0] r;
      if (v > 50'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -50'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   logic signed [31:0] pos_mem [NUM_P];
   logic signed [31:0] vel_mem [NUM_P];
   logic [15:0]        mass_mem [NUM_P];
   logic [30:0]        rad_mem [NUM_P];

   logic signed [31:0] lw_ff, rw_ff;
   logic [CNT_W-1:0]   cnt_ff;

   logic signed [31:0] rd_x_ff, rd_v_ff, cur_x_ff, cur_v_ff, prev_x_ff, prev_v_ff;
   logic [15:0]        rd_m_ff, cur_m_ff, prev_m_ff;
   logic [30:0]        rd_r_ff, cur_r_ff, prev_r_ff;

   logic [31:0]        best_ff;
   logic [1:0]         kind_ff, pend_kind_ff;
   logic [IDX_W-1:0]   idx_ff, pend_idx_ff;
   logic               mom_ff;
   logic [63:0]        prod_ff;
   logic signed [49:0] p0_ff, p1_ff, sum_ff;
   hrg_rsp_type        rsp_ff, rsp_in;

   logic signed [35:0] num;
   logic signed [33:0] den;
   logic [35:0]        num_mag;
   logic [33:0]        den_mag;
   logic               cand_ok;
   logic               div_start, div_busy, div_done;
   logic [DIVN_W-1:0]  div_n, div_q;
   logic [DIVD_W-1:0]  div_d, div_r;
   logic [31:0]        t_sat;
   logic [31:0]        vmag;
   logic signed [49:0] adv_x;
   logic signed [31:0] neg_v;
   logic               both_zero;
   logic [16:0]        m0e, m1e, msum;
   logic [49:0]        sum_mag;
   logic signed [35:0] qs, u;
   logic signed [37:0] new_v0, new_v1;

   always_comb begin
      num = '0;
      den = '0;
      unique case (cmd.cand)
         KIND_LEFT: begin
            num = 36'(cur_x_ff) - 36'(lw_ff) - 36'(cur_r_ff);
            den = -34'(cur_v_ff);
         end
         KIND_PAIR: begin
            num = 36'(cur_x_ff) - 36'(prev_x_ff) - 36'(cur_r_ff) - 36'(prev_r_ff);
            den = 34'(prev_v_ff) - 34'(cur_v_ff);
         end
         KIND_RIGHT: begin
            num = 36'(rw_ff) - 36'(cur_x_ff) - 36'(cur_r_ff);
            den = 34'(cur_v_ff);
         end
         default: begin
            num = '0;
            den = '0;
         end
      endcase
   end

   // A zero gap counts only when the bodies close, which the sign test covers.
   assign cand_ok = (cmd.cand != KIND_NONE) && (den != '0) && (num[35] == den[33]);
   assign num_mag = num[35] ? 36'(-num) : 36'(num);
   assign den_mag = den[33] ? 34'(-den) : 34'(den);

   assign both_zero = (prev_m_ff == 16'd0) && (cur_m_ff == 16'd0);
   assign m0e  = both_zero ? 17'd1 : {1'b0, prev_m_ff};
   assign m1e  = both_zero ? 17'd1 : {1'b0, cur_m_ff};
   assign msum = m0e + m1e;
   assign sum_mag = sum_ff[49] ? 50'(-sum_ff) : 50'(sum_ff);

   assign div_start = (cmd.cand != KIND_NONE && cand_ok) || cmd.div_mom;
   assign div_n = cmd.div_mom ? {1'b0, sum_mag} : {num_mag[34:0], 16'b0};
   assign div_d = cmd.div_mom ? {15'b0, msum} : den_mag[31:0];

   hrg_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_n),
      .divisor   (div_d),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   assign t_sat = (div_q[DIVN_W-1:32] != '0) ? 32'hFFFFFFFF : div_q[31:0];

   assign vmag  = cur_v_ff[31] ? (~cur_v_ff + 32'd1) : cur_v_ff;
   assign adv_x = cur_v_ff[31] ? (50'(cur_x_ff) - 50'(prod_ff[63:16]))
                               : (50'(cur_x_ff) + 50'(prod_ff[63:16]));
   assign neg_v = (cur_v_ff == 32'sh80000000) ? 32'sh7FFFFFFF : -cur_v_ff;

   // Floor of the signed momentum sum over the total mass.
   assign qs = {2'b00, div_q[33:0]};
   assign u  = sum_ff[49] ? (-qs - 36'(div_r != '0)) : qs;
   assign new_v0 = (38'(u) <<< 1) - 38'(prev_v_ff);
   assign new_v1 = (38'(u) <<< 1) - 38'(cur_v_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         lw_ff   <= '0;
         rw_ff   <= 32'sd65536;
         cnt_ff  <= 6'd32;
         kind_ff <= KIND_NONE;
         mom_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_LEFT_WALL:  lw_ff  <= csr_wdata;
               CSR_RIGHT_WALL: rw_ff  <= csr_wdata;
               CSR_COUNT:      cnt_ff <= csr_wdata[CNT_W-1:0];
               default: ;
            endcase
         end
         if (div_start) begin
            mom_ff <= cmd.div_mom;
         end
         if (cmd.clr_best) begin
            kind_ff <= KIND_NONE;
         end else if (div_done && !mom_ff &&
                      (kind_ff == KIND_NONE || t_sat < best_ff)) begin
            kind_ff <= pend_kind_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_best) begin
         best_ff <= '0;
         idx_ff  <= '0;
      end else if (div_done && !mom_ff &&
                   (kind_ff == KIND_NONE || t_sat < best_ff)) begin
         best_ff <= t_sat;
         idx_ff  <= pend_idx_ff;
      end
      if (div_start && !cmd.div_mom) begin
         pend_kind_ff <= cmd.cand;
         pend_idx_ff  <= cmd.cand_idx;
      end
      if (cmd.rd_en) begin
         rd_x_ff <= pos_mem[cmd.rd_addr];
         rd_v_ff <= vel_mem[cmd.rd_addr];
         rd_m_ff <= mass_mem[cmd.rd_addr];
         rd_r_ff <= rad_mem[cmd.rd_addr];
      end
      if (cmd.cap) begin
         prev_x_ff <= cur_x_ff;
         prev_v_ff <= cur_v_ff;
         prev_m_ff <= cur_m_ff;
         prev_r_ff <= cur_r_ff;
         cur_x_ff  <= rd_x_ff;
         cur_v_ff  <= rd_v_ff;
         cur_m_ff  <= rd_m_ff;
         cur_r_ff  <= rd_r_ff;
      end
      if (cmd.mul_adv) begin
         prod_ff <= {32'b0, vmag} * {32'b0, best_ff};
      end
      if (cmd.mul_mom) begin
         p0_ff <= 50'($signed({1'b0, m0e})) * 50'(prev_v_ff);
         p1_ff <= 50'($signed({1'b0, m1e})) * 50'(cur_v_ff);
      end
      if (cmd.sum_mom) begin
         sum_ff <= p0_ff + p1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_load) begin
         pos_mem[req_beat.slot]  <= req_beat.position_in;
         vel_mem[req_beat.slot]  <= req_beat.velocity_in;
         mass_mem[req_beat.slot] <= req_beat.mass_in;
         rad_mem[req_beat.slot]  <= req_beat.radius_in;
      end else begin
         if (cmd.wr_pos) begin
            pos_mem[cmd.wr_addr] <= sat32(adv_x);
         end
         if (cmd.wr_neg) begin
            vel_mem[cmd.wr_addr] <= neg_v;
         end else if (cmd.wr_pair0) begin
            vel_mem[cmd.wr_addr] <= sat32(50'(new_v0));
         end else if (cmd.wr_pair1) begin
            vel_mem[cmd.wr_addr] <= sat32(50'(new_v1));
         end
      end
   end

   always_comb begin
      rsp_in = '0;
      unique case (cmd.rsp_sel)
         RSP_READ: begin
            rsp_in.position_out = rd_x_ff;
            rsp_in.velocity_out = rd_v_ff;
         end
         RSP_STEP: begin
            if (kind_ff != KIND_NONE) begin
               rsp_in.event_kind  = kind_ff;
               rsp_in.event_index = idx_ff;
               rsp_in.event_time  = best_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_beat      = rsp_ff;
   assign status.n_zero = (cnt_ff == '0);
   assign status.last   = (cnt_ff > 6'd32) ? 5'd31 : 5'(cnt_ff - 6'd1);
   assign status.busy   = div_busy;
   assign status.kind   = kind_ff;
   assign status.idx    = idx_ff;

endmodule

### hdl/hrg_ctrl.sv
// Controller: handshakes and the sequence of a step over the particle stores.
`timescale 1ns / 1ps
module hrg_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  hrg_pkg::hrg_req_type    req_beat,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output hrg_pkg::hrg_cmd_type    cmd,
   input  hrg_pkg::hrg_status_type status
);
   import hrg_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_RD_WAIT, S_CAP0, S_LEFT, S_SWAIT, S_PCAP, S_PAIR, S_RIGHT,
      S_RWAIT, S_ACAP, S_AMUL, S_AWR, S_VEL, S_NCAP, S_NWR, S_MCAP0, S_MCAP1,
      S_MMUL, S_MSUM, S_MDIV, S_MWAIT, S_MWR0, S_MWR1, S_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free, req_take;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == S_IDLE) && out_free);
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      cmd          = '0;
      cmd.rsp_sel  = RSP_ZERO;
      state_in     = state_ff;
      i_in         = i_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               unique case (req_beat.mode)
                  MODE_LOAD: begin
                     cmd.wr_load  = 1'b1;
                     cmd.rsp_load = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
                  MODE_READ: begin
                     cmd.rd_en   = 1'b1;
                     cmd.rd_addr = req_beat.slot;
                     state_in    = S_RD_WAIT;
                  end
                  MODE_STEP: begin
                     if (status.n_zero) begin
                        cmd.rsp_load = 1'b1;
                        rsp_valid_in = 1'b1;
                     end else begin
                        cmd.clr_best = 1'b1;
                        cmd.rd_en    = 1'b1;
                        i_in         = '0;
                        state_in     = S_CAP0;
                     end
                  end
                  default: begin
                     cmd.rsp_load = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_RD_WAIT: begin
            cmd.rsp_load = 1'b1;
            cmd.rsp_sel  = RSP_READ;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_CAP0: begin
            cmd.cap  = 1'b1;
            state_in = S_LEFT;
         end
         S_LEFT: begin
            cmd.cand = KIND_LEFT;
            state_in = S_SWAIT;
         end
         S_SWAIT: begin
            if (!status.busy) begin
               if (i_ff == status.last) begin
                  state_in = S_RIGHT;
               end else begin
                  cmd.rd_en   = 1'b1;
                  cmd.rd_addr = i_ff + 5'd1;
                  i_in        = i_ff + 5'd1;
                  state_in    = S_PCAP;
               end
            end
         end
         S_PCAP: begin
            cmd.cap  = 1'b1;
            state_in = S_PAIR;
         end
         S_PAIR: begin
            cmd.cand     = KIND_PAIR;
            cmd.cand_idx = i_ff - 5'd1;
            state_in     = S_SWAIT;
         end
         S_RIGHT: begin
            cmd.cand     = KIND_RIGHT;
            cmd.cand_idx = i_ff;
            state_in     = S_RWAIT;
         end
         S_RWAIT: begin
            if (!status.busy) begin
               if (status.kind == KIND_NONE) begin
                  state_in = S_DONE;
               end else begin
                  cmd.rd_en = 1'b1;
                  i_in      = '0;
                  state_in  = S_ACAP;
               end
            end
         end
         S_ACAP: begin
            cmd.cap  = 1'b1;
            state_in = S_AMUL;
         end
         S_AMUL: begin
            cmd.mul_adv = 1'b1;
            state_in    = S_AWR;
         end
         S_AWR: begin
            cmd.wr_pos  = 1'b1;
            cmd.wr_addr = i_ff;
            if (i_ff == status.last) begin
               state_in = S_VEL;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = i_ff + 5'd1;
               i_in        = i_ff + 5'd1;
               state_in    = S_ACAP;
            end
         end
         S_VEL: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = status.idx;
            state_in    = (status.kind == KIND_PAIR) ? S_MCAP0 : S_NCAP;
         end
         S_NCAP: begin
            cmd.cap  = 1'b1;
            state_in = S_NWR;
         end
         S_NWR: begin
            cmd.wr_neg  = 1'b1;
            cmd.wr_addr = status.idx;
            state_in    = S_DONE;
         end
         S_MCAP0: begin
            cmd.cap     = 1'b1;
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = status.idx + 5'd1;
            state_in    = S_MCAP1;
         end
         S_MCAP1: begin
            cmd.cap  = 1'b1;
            state_in = S_MMUL;
         end
         S_MMUL: begin
            cmd.mul_mom = 1'b1;
            state_in    = S_MSUM;
         end
         S_MSUM: begin
            cmd.sum_mom = 1'b1;
            state_in    = S_MDIV;
         end
         S_MDIV: begin
            cmd.div_mom = 1'b1;
            state_in    = S_MWAIT;
         end
         S_MWAIT: begin
            if (!status.busy) begin
               state_in = S_MWR0;
            end
         end
         S_MWR0: begin
            cmd.wr_pair0 = 1'b1;
            cmd.wr_addr  = status.idx;
            state_in     = S_MWR1;
         end
         S_MWR1: begin
            cmd.wr_pair1 = 1'b1;
            cmd.wr_addr  = status.idx + 5'd1;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_sel  = RSP_STEP;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         i_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### hdl/hard_rod_gas_event_step_top.sv
// Usage:
// Input beats on req_* carry a mode: load writes one particle, step runs the
// collision search and advance, read returns one particle; any other mode
// answers with an all-zero result. Every input beat gives one result beat on
// rsp_*, in order. The csr_* port writes left wall, right wall and particle
// count; the user must write them only while the block is idle, since the
// block itself does not enforce this. Writes take effect at once. A load
// answers in the cycle after acceptance; a read passes through the read
// register and then the result register. A step computes its n+1 candidate
// times in turn through one shared restoring divider that yields one quotient
// bit per cycle; on an event it advances all rods, then bounces or exchanges.
// One item is worked on at a time; req_stall is high while a step runs.
// The result register lets a new beat be accepted while the previous result
// is taken in the same cycle; when rsp_stall holds a result, the next one
// waits in the block and no new beat is accepted.
// Reset clears the control state and restores the register defaults; the
// particle stores hold nothing valid until loaded.
`timescale 1ns / 1ps
module hard_rod_gas_event_step_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  hrg_pkg::hrg_req_type          req_beat,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output hrg_pkg::hrg_rsp_type          rsp_beat,
   input  logic                          csr_we,
   input  logic [hrg_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [hrg_pkg::VAL_W-1:0]     csr_wdata
);
   import hrg_pkg::*;

   hrg_cmd_type    cmd;
   hrg_status_type status;

   hrg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_beat  (req_beat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   hrg_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_beat  (req_beat),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_beat  (rsp_beat)
   );

endmodule

### tb/sv/hard_rod_gas_event_step_top_test.sv
// Self-checking testbench for the hard rod gas event step block.
`timescale 1ns / 1ps
module hard_rod_gas_event_step_top_test;
   import hrg_pkg::*;

   localparam logic [1:0] MODE_IDLE = 2'd3;
   localparam longint VMAX = 64'sh7FFF_FFFF;
   localparam longint VMIN = -64'sh8000_0000;
   localparam int TAIL_CYCLES = 20;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   hrg_req_type req_beat = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   hrg_rsp_type rsp_beat;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [VAL_W-1:0] csr_wdata = '0;

   hard_rod_gas_event_step_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_beat(req_beat),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_beat(rsp_beat),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Predicted gas state and register copies.
   longint gas_pos[NUM_P];
   longint gas_vel[NUM_P];
   longint gas_rad[NUM_P];
   longint gas_mass[NUM_P];
   longint wall_lo = 0;
   longint wall_hi = 65536;
   int rod_count = 32;

   hrg_req_type pending_q[$];
   hrg_rsp_type result_q[$];
   int sent_cnt = 0;
   int taken_cnt = 0;
   int error_cnt = 0;
   bit req_taken = 1'b0;
   bit quiet = 1'b0;
   bit long_hold = 1'b0;
   int gap_cnt = 0;
   int hold_cnt = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic longint sat32(longint v);
      if (v > VMAX) return VMAX;
      if (v < VMIN) return VMIN;
      return v;
   endfunction

   function automatic longint mag(longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic bit hit_time(longint num, longint den, output longint t);
      longint a, d, ip, rem;
      t = 0;
      if (den == 0) return 1'b0;
      if (num == 0) begin
         if (den < 0) return 1'b0;
      end else if ((num < 0) != (den < 0)) begin
         return 1'b0;
      end
      a = mag(num);
      d = mag(den);
      ip = a / d;
      rem = a % d;
      if (ip >= 65536) begin
         t = 64'hFFFF_FFFF;
         return 1'b1;
      end
      for (int k = 0; k < 16; k++) begin
         rem = rem << 1;
         ip = ip << 1;
         if (rem >= d) begin
            rem = rem - d;
            ip = ip | 1;
         end
      end
      t = ip;
      return 1'b1;
   endfunction

   function automatic longint advance_pos(longint x, longint v, longint t);
      longint m, th, tl, cap, d;
      m = mag(v);
      th = t >>> 16;
      tl = t & 64'hFFFF;
      cap = 64'sh2_0000_0000;
      if (th != 0 && m > cap / th) d = cap;
      else d = m * th + ((m * tl) >>> 16);
      if (d > cap) d = cap;
      return sat32((v < 0) ? x - d : x + d);
   endfunction

   // Applies one accepted beat to the predicted gas and returns its result.
   function automatic hrg_rsp_type gas_apply(hrg_req_type rq);
      hrg_rsp_type r;
      int n, last;
      longint t, best, m0, m1, ms, q0, q1, r0, r1, u, v0, v1;
      logic [1:0] kind;
      int idx;
      r = '0;
      case (rq.mode)
         MODE_LOAD: begin
            gas_pos[rq.slot] = longint'(rq.position_in);
            gas_vel[rq.slot] = longint'(rq.velocity_in);
            gas_mass[rq.slot] = longint'(rq.mass_in);
            gas_rad[rq.slot] = longint'({1'b0, rq.radius_in});
         end
         MODE_READ: begin
            r.position_out = gas_pos[rq.slot][31:0];
            r.velocity_out = gas_vel[rq.slot][31:0];
         end
         MODE_STEP: begin
            n = (rod_count > NUM_P) ? NUM_P : rod_count;
            kind = KIND_NONE;
            idx = 0;
            best = 0;
            if (n != 0) begin
               last = n - 1;
               if (hit_time(gas_pos[0] - wall_lo - gas_rad[0], -gas_vel[0], t)) begin
                  kind = KIND_LEFT;
                  best = t;
               end
               for (int i = 0; i + 1 < n; i++) begin
                  if (hit_time(gas_pos[i+1] - gas_pos[i] - gas_rad[i+1] - gas_rad[i],
                               gas_vel[i] - gas_vel[i+1], t)
                      && (kind == KIND_NONE || t < best)) begin
                     kind = KIND_PAIR;
                     idx = i;
                     best = t;
                  end
               end
               if (hit_time(wall_hi - gas_pos[last] - gas_rad[last], gas_vel[last], t)
                   && (kind == KIND_NONE || t < best)) begin
                  kind = KIND_RIGHT;
                  idx = last;
                  best = t;
               end
            end
            if (kind != KIND_NONE) begin
               for (int i = 0; i < n; i++)
                  gas_pos[i] = advance_pos(gas_pos[i], gas_vel[i], best);
               if (kind == KIND_LEFT) begin
                  gas_vel[0] = sat32(-gas_vel[0]);
               end else if (kind == KIND_RIGHT) begin
                  gas_vel[idx] = sat32(-gas_vel[idx]);
               end else begin
                  m0 = gas_mass[idx];
                  m1 = gas_mass[idx+1];
                  v0 = gas_vel[idx];
                  v1 = gas_vel[idx+1];
                  if (m0 + m1 == 0) begin
                     m0 = 1;
                     m1 = 1;
                  end
                  ms = m0 + m1;
                  // Split the momentum sum so the floor of the mean stays exact.
                  q0 = (m0 * v0) / ms;
                  r0 = (m0 * v0) % ms;
                  if (r0 < 0) begin
                     q0 = q0 - 1;
                     r0 = r0 + ms;
                  end
                  q1 = (m1 * v1) / ms;
                  r1 = (m1 * v1) % ms;
                  if (r1 < 0) begin
                     q1 = q1 - 1;
                     r1 = r1 + ms;
                  end
                  u = q0 + q1 + ((r0 + r1 >= ms) ? 1 : 0);
                  gas_vel[idx] = sat32(2 * u - v0);
                  gas_vel[idx+1] = sat32(2 * u - v1);
               end
               r.event_kind = kind;
               r.event_index = idx[4:0];
               r.event_time = best[31:0];
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // Driver: one beat at a time, with a random gap after each beat unless quiet.
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (gap_cnt != 0) begin
            gap_cnt = gap_cnt - 1;
            req_valid <= 1'b0;
         end else if (pending_q.size() != 0) begin
            req_beat <= pending_q.pop_front();
            req_valid <= 1'b1;
            sent_cnt = sent_cnt + 1;
            gap_cnt = quiet ? 0 : $urandom_range(0, 7);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver stall, with one long hold-off on request.
   always @(negedge clock) begin
      if (long_hold) begin
         long_hold = 1'b0;
         hold_cnt = 400;
      end
      if (hold_cnt != 0) begin
         hold_cnt = hold_cnt - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      req_taken = !reset && req_valid && !req_stall;
      if (req_taken) begin
         result_q = {result_q, gas_apply(req_beat)};
         taken_cnt = taken_cnt + 1;
      end
   end

   always @(posedge clock) begin
      hrg_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (result_q.size() == 0) begin
            $error("result beat with nothing expected");
            error_cnt++;
         end else begin
            want = result_q.pop_front();
            if (rsp_beat.event_kind !== want.event_kind) begin
               $error("event_kind expected %0d got %0d", want.event_kind, rsp_beat.event_kind);
               error_cnt++;
            end
            if (rsp_beat.event_index !== want.event_index) begin
               $error("event_index expected %0d got %0d", want.event_index,
                      rsp_beat.event_index);
               error_cnt++;
            end
            if (rsp_beat.event_time !== want.event_time) begin
               $error("event_time expected %h got %h", want.event_time, rsp_beat.event_time);
               error_cnt++;
            end
            if (rsp_beat.position_out !== want.position_out) begin
               $error("position_out expected %h got %h", want.position_out,
                      rsp_beat.position_out);
               error_cnt++;
            end
            if (rsp_beat.velocity_out !== want.velocity_out) begin
               $error("velocity_out expected %h got %h", want.velocity_out,
                      rsp_beat.velocity_out);
               error_cnt++;
            end
         end
         if (!quiet && hold_cnt == 0) hold_cnt = $urandom_range(0, 7);
      end
   end

   task automatic add_beat(logic [1:0] mode, int slot, logic [31:0] pos, logic [31:0] vel,
                           logic [31:0] mass, logic [31:0] rad);
      hrg_req_type rq;
      rq.mode = mode;
      rq.slot = slot[4:0];
      rq.position_in = pos;
      rq.velocity_in = vel;
      rq.mass_in = mass[15:0];
      rq.radius_in = rad[30:0];
      pending_q = {pending_q, rq};
   endtask

   task automatic drain;
      while (pending_q.size() != 0 || sent_cnt != taken_cnt || result_q.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] index, logic [31:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         CSR_LEFT_WALL: wall_lo = longint'(signed'(value));
         CSR_RIGHT_WALL: wall_hi = longint'(signed'(value));
         CSR_COUNT: rod_count = int'(value[5:0]);
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // A sorted gas between the walls, then a mix of steps, reads, reloads and idle-mode beats.
   task automatic gas_phase(int count);
      longint x, lo, r, prev_r;
      int beats;
      lo = longint'($urandom_range(0, 1 << 24)) - (1 << 23);
      csr_write(CSR_LEFT_WALL, lo[31:0]);
      csr_write(CSR_COUNT, count);
      x = lo;
      prev_r = 0;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 1 << 16);
         x = x + prev_r + r + $urandom_range(1, 4 << 16);
         add_beat(MODE_LOAD, i, x[31:0],
                  32'($urandom_range(0, 1 << 18)) - 32'(1 << 17),
                  ($urandom_range(0, 3) == 0) ? 32'($urandom_range(1, 4))
                                              : 32'($urandom_range(1, 65535)),
                  r[31:0]);
         prev_r = r;
      end
      x = x + prev_r + $urandom_range(1, 4 << 16);
      // The loads must be through before the wall register changes.
      drain();
      csr_write(CSR_RIGHT_WALL, x[31:0]);
      beats = $urandom_range(15, 30);
      for (int k = 0; k < beats; k++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: add_beat(MODE_STEP, $urandom_range(0, 31), $urandom, $urandom,
                                 $urandom, $urandom);
            4: add_beat(MODE_IDLE, $urandom_range(0, 31), $urandom, $urandom, $urandom,
                        $urandom);
            5: add_beat(MODE_LOAD, $urandom_range(0, 31), $urandom, $urandom, $urandom,
                        $urandom);
            default: add_beat(MODE_READ, $urandom_range(0, 31), $urandom, $urandom,
                              $urandom, $urandom);
         endcase
      end
   endtask

   task automatic noise_phase;
      int beats;
      csr_write(CSR_LEFT_WALL, $urandom);
      csr_write(CSR_RIGHT_WALL, $urandom);
      csr_write(CSR_COUNT, $urandom_range(0, 63));
      beats = $urandom_range(10, 25);
      for (int k = 0; k < beats; k++)
         add_beat(2'($urandom_range(0, 3)), $urandom_range(0, 31), $urandom, $urandom,
                  $urandom, $urandom);
   endtask

   initial begin
      int base_cnt;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Three rods: left wall, pair of massless rods, right wall.
      csr_write(CSR_RIGHT_WALL, 100 << 16);
      csr_write(CSR_COUNT, 3);
      add_beat(MODE_LOAD, 0, 10 << 16, -(1 << 16), 1, 1 << 16);
      add_beat(MODE_LOAD, 1, 50 << 16, 5 << 16, 0, 0);
      add_beat(MODE_LOAD, 2, 90 << 16, -(5 << 16), 0, 0);
      repeat (4) add_beat(MODE_STEP, 0, 0, 0, 0, 0);
      add_beat(MODE_READ, 0, 0, 0, 0, 0);
      add_beat(MODE_READ, 2, 0, 0, 0, 0);
      add_beat(MODE_IDLE, 31, '1, '1, '1, '1);
      // Rod touching the left wall and moving into it: zero time.
      add_beat(MODE_LOAD, 0, 1 << 16, -5, 7, 1 << 16);
      add_beat(MODE_STEP, 0, 0, 0, 0, 0);
      drain();
      csr_write(CSR_COUNT, 0);
      add_beat(MODE_STEP, 0, 0, 0, 0, 0);
      // Fill every slot, extreme values first.
      add_beat(MODE_LOAD, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_FFFF, 32'h7FFF_FFFF);
      add_beat(MODE_LOAD, 1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0);
      for (int i = 2; i < NUM_P; i++)
         add_beat(MODE_LOAD, i, $urandom, $urandom, $urandom, $urandom);
      drain();
      csr_write(CSR_LEFT_WALL, 32'h8000_0000);
      csr_write(CSR_RIGHT_WALL, 32'h7FFF_FFFF);
      csr_write(CSR_COUNT, 63);
      add_beat(MODE_STEP, 0, 0, 0, 0, 0);
      add_beat(MODE_READ, 31, 0, 0, 0, 0);
      drain();
      csr_write(CSR_COUNT, 1);
      add_beat(MODE_STEP, 0, 0, 0, 0, 0);
      add_beat(MODE_STEP, 0, 0, 0, 0, 0);
      drain();

      // Back-pressure: results held while reads keep coming.
      long_hold = 1'b1;
      for (int k = 0; k < 12; k++)
         add_beat(MODE_READ, k, 0, 0, 0, 0);
      drain();

      base_cnt = sent_cnt;
      while (sent_cnt - base_cnt < 440) begin
         quiet = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 4) == 0) begin
            noise_phase();
         end else begin
            case ($urandom_range(0, 3))
               0: gas_phase(NUM_P);
               1: gas_phase(1);
               default: gas_phase($urandom_range(2, 12));
            endcase
         end
         drain();
      end

      if (error_cnt == 0 && result_q.size() == 0) begin
         $display("hard_rod_gas_event_step_top test passed");
      end else begin
         $display("hard_rod_gas_event_step_top test failed");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("hard_rod_gas_event_step_top test failed");
      $finish;
   end

endmodule

### hard_rod_gas_event_step_top.f
hdl/hrg_pkg.sv
hdl/hrg_div.sv
hdl/hrg_dp.sv
hdl/hrg_ctrl.sv
hdl/hard_rod_gas_event_step_top.sv
tb/sv/hard_rod_gas_event_step_top_test.sv
